FILE: rtl/bpq_pkg.sv
// Package with the shared types and constants of the bounded priority queue.
package bpq_pkg;

  localparam int unsigned PRIO_W = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_IDENT_W = 32;

  localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPRIO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [PRIO_W-1:0] prio;
  } cell_ctrl_t;

endpackage

FILE: rtl/bpq_cell.sv
// One storage cell of the sorted shift-register queue.
module bpq_cell #(
  parameter int unsigned IDENT_BITS = 32,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic                      clk,
  input  bpq_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic [IDENT_BITS-1:0]     new_ident_i,
  input  logic                      prev_keep_i,
  input  logic [bpq_pkg::PRIO_W-1:0] left_prio_i,
  input  logic [IDENT_BITS-1:0]     left_ident_i,
  input  logic [bpq_pkg::PRIO_W-1:0] right_prio_i,
  input  logic [IDENT_BITS-1:0]     right_ident_i,
  output logic                      keep_o,
  output logic [bpq_pkg::PRIO_W-1:0] prio_o,
  output logic [IDENT_BITS-1:0]     ident_o
);

  logic [bpq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [IDENT_BITS-1:0]      ident_r, ident_nxt;
  logic                       occupied;

  // A cell keeps its entry when it is occupied and outranks or equals the new request.
  assign occupied = (CNT_W'(INDEX) < count_i);
  assign keep_o = occupied && (prio_r >= ctrl_i.prio);

  always_comb begin
    prio_nxt = prio_r;
    ident_nxt = ident_r;
    case (ctrl_i.op)
      bpq_pkg::OP_INSERT: begin
        if (keep_o) begin
          prio_nxt = prio_r;
          ident_nxt = ident_r;
        end else if (prev_keep_i) begin
          prio_nxt = ctrl_i.prio;
          ident_nxt = new_ident_i;
        end else begin
          prio_nxt = left_prio_i;
          ident_nxt = left_ident_i;
        end
      end
      bpq_pkg::OP_REMOVE: begin
        prio_nxt = right_prio_i;
        ident_nxt = right_ident_i;
      end
      default: begin
        prio_nxt = prio_r;
        ident_nxt = ident_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    ident_r <= ident_nxt;
  end

  assign prio_o = prio_r;
  assign ident_o = ident_r;

endmodule

FILE: rtl/bounded_priority_queue_core.sv
// Top level of the bounded priority queue built as a row of shift-register cells.
//
//  Channel  Handshake              Payload
//  in       start / busy           in_action, in_priority_req, in_ident
//  out      out_valid (one cycle)  out_status, out_ident, out_priority
//
// Each request is accepted at a clock edge and its result is shown
// with out_valid in the following cycle, so a new request can be accepted at every edge.
// All cells compare against the new priority at once and shift in the same cycle.
// Synchronous reset empties the queue; the cell contents are not cleared.
// The receiver cannot stall, so busy stays low.
module bounded_priority_queue_core #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IDENT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [bpq_pkg::PRIO_W-1:0]    in_priority_req,
  input  logic [IDENT_BITS-1:0]         in_ident,
  output logic                          out_valid,
  output logic [bpq_pkg::STATUS_W-1:0]  out_status,
  output logic [bpq_pkg::OUT_IDENT_W-1:0] out_ident,
  output logic [bpq_pkg::PRIO_W-1:0]    out_priority
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     bad_prio;
  logic                     is_empty;
  logic                     is_full;
  bpq_pkg::cell_ctrl_t      ctrl;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     valid_r, valid_nxt;
  logic [bpq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [bpq_pkg::OUT_IDENT_W-1:0] ident_r, ident_nxt;
  logic [bpq_pkg::PRIO_W-1:0] prio_r, prio_nxt;

  logic [bpq_pkg::PRIO_W-1:0] cell_prio [CAPACITY];
  logic [IDENT_BITS-1:0]      cell_ident [CAPACITY];
  logic                       cell_keep [CAPACITY];
  logic [bpq_pkg::OUT_IDENT_W+IDENT_BITS-1:0] front_ident_ext;

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign bad_prio = (in_priority_req < bpq_pkg::PRIO_MIN) ||
                    (in_priority_req > bpq_pkg::PRIO_MAX);
  assign is_empty = (count_r == '0);
  assign is_full = (count_r == CNT_W'(CAPACITY));
  assign front_ident_ext = {{bpq_pkg::OUT_IDENT_W{1'b0}}, cell_ident[0]};

  always_comb begin
    ctrl.op = bpq_pkg::OP_HOLD;
    ctrl.prio = in_priority_req;
    if (accept) begin
      if (in_action == bpq_pkg::ACT_ENQUEUE) begin
        if (!bad_prio && !is_full) begin
          ctrl.op = bpq_pkg::OP_INSERT;
        end
      end else if (!is_empty) begin
        ctrl.op = bpq_pkg::OP_REMOVE;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    valid_nxt = accept;
    status_nxt = bpq_pkg::ST_OK;
    ident_nxt = '0;
    prio_nxt = '0;
    case (ctrl.op)
      bpq_pkg::OP_INSERT: count_nxt = count_r + CNT_W'(1);
      bpq_pkg::OP_REMOVE: begin
        count_nxt = count_r - CNT_W'(1);
        ident_nxt = front_ident_ext[bpq_pkg::OUT_IDENT_W-1:0];
        prio_nxt = cell_prio[0];
      end
      default: count_nxt = count_r;
    endcase
    if (in_action == bpq_pkg::ACT_ENQUEUE) begin
      if (bad_prio) begin
        status_nxt = bpq_pkg::ST_BADPRIO;
      end else if (is_full) begin
        status_nxt = bpq_pkg::ST_FULL;
      end
    end else if (is_empty) begin
      status_nxt = bpq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    ident_r <= ident_nxt;
    prio_r <= prio_nxt;
  end

  assign out_valid = valid_r;
  assign out_status = status_r;
  assign out_ident = ident_r;
  assign out_priority = prio_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       prev_keep;
    logic [bpq_pkg::PRIO_W-1:0] left_prio;
    logic [IDENT_BITS-1:0]      left_ident;
    logic [bpq_pkg::PRIO_W-1:0] right_prio;
    logic [IDENT_BITS-1:0]      right_ident;

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign left_prio = '0;
      assign left_ident = '0;
    end else begin : g_inner_left
      assign prev_keep = cell_keep[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_ident = cell_ident[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_prio = '0;
      assign right_ident = '0;
    end else begin : g_inner_right
      assign right_prio = cell_prio[i+1];
      assign right_ident = cell_ident[i+1];
    end

    bpq_cell #(
      .IDENT_BITS(IDENT_BITS),
      .CNT_W(CNT_W),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .ctrl_i(ctrl),
      .count_i(count_r),
      .new_ident_i(in_ident),
      .prev_keep_i(prev_keep),
      .left_prio_i(left_prio),
      .left_ident_i(left_ident),
      .right_prio_i(right_prio),
      .right_ident_i(right_ident),
      .keep_o(cell_keep[i]),
      .prio_o(cell_prio[i]),
      .ident_o(cell_ident[i])
    );
  end

endmodule

FILE: rtl/bpq_checker.sv
// Port-level checker for the bounded priority queue, bound to the top level.
module bpq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_action,
  input logic [bpq_pkg::PRIO_W-1:0]     in_priority_req,
  input logic                           out_valid,
  input logic [bpq_pkg::STATUS_W-1:0]   out_status,
  input logic [bpq_pkg::OUT_IDENT_W-1:0] out_ident,
  input logic [bpq_pkg::PRIO_W-1:0]     out_priority
);

  // Every accepted request gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted request gave no result");

  // No result appears without a request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without a request");

  // An enqueue with a priority out of range is refused.
  a_bad_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == bpq_pkg::ACT_ENQUEUE) &&
     ((in_priority_req < bpq_pkg::PRIO_MIN) || (in_priority_req > bpq_pkg::PRIO_MAX)))
    |=> (out_status == bpq_pkg::ST_BADPRIO))
    else $error("bad priority not refused");

  // Error results carry no entry.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != bpq_pkg::ST_OK))
    |-> ((out_ident == '0) && (out_priority == '0)))
    else $error("error result carries an entry");

  // A removed entry never has a priority above PRIO_MAX.
  a_removed_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == bpq_pkg::ST_OK) && (out_priority != '0))
    |-> (out_priority <= bpq_pkg::PRIO_MAX))
    else $error("removed entry has an illegal priority");

endmodule

bind bounded_priority_queue_core bpq_checker u_bpq_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_action(in_action),
  .in_priority_req(in_priority_req),
  .out_valid(out_valid),
  .out_status(out_status),
  .out_ident(out_ident),
  .out_priority(out_priority)
);
